@@ sv/csa_pkg.sv @@
// Shared types and codes of the compacting slot allocator.
package csa_pkg;

    localparam int OFFSET_W = 13;
    localparam int SIZE_W   = 13;
    localparam int HANDLE_W = 8;
    localparam int STATUS_W = 3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_GRANTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MOVED    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REFUSED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [HANDLE_W-1:0] owner;
        logic [SIZE_W-1:0]   size;
    } t_entry;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ALLOC = 6'b000010,
        S_RD    = 6'b000100,
        S_CMP   = 6'b001000,
        S_MRD   = 6'b010000,
        S_MOVE  = 6'b100000
    } t_state;

endpackage

@@ sv/compacting_slot_allocator.sv @@
// Compacting slot allocator: packed slot table with iterative scan and compaction.
// Allocate: S_ALLOC registers the result when the output is free; the running total is kept.
// Free: S_RD and S_CMP scan each table entry through the hit, then S_MRD and S_MOVE move each
// later entry down one place; a miss ends in S_RD at the end of the used prefix.
// One transaction in work at a time; a new one is taken the cycle after the last result is
// registered. Reset (synchronous, active low) empties the table at once through the fill count.
module compacting_slot_allocator #(
    parameter int SLOTS    = 16,
    parameter int CAPACITY = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic [7:0]  i_owner_handle,
    input  logic [12:0] i_request_size,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [7:0]  o_result_handle,
    output logic [12:0] o_result_offset,
    output logic        o_last
);

    localparam int IW   = $clog2(SLOTS);
    localparam int CNTW = $clog2(SLOTS + 1);
    localparam int TW   = $clog2(CAPACITY + 1);
    // Width for the capacity check: total plus a full request never wraps.
    localparam int CW   = ((TW > csa_pkg::SIZE_W) ? TW : csa_pkg::SIZE_W) + 1;

    csa_pkg::t_state r_state, n_state;

    logic                        r_op, n_op;
    logic [csa_pkg::HANDLE_W-1:0] r_handle, n_handle;
    logic [csa_pkg::SIZE_W-1:0]   r_size, n_size;
    logic [CNTW-1:0]             r_count, n_count;
    logic [TW-1:0]               r_total, n_total;
    logic [CNTW-1:0]             r_idx, n_idx;
    logic [TW-1:0]               r_vol, n_vol;

    logic                         r_out_valid, n_out_valid;
    logic [csa_pkg::STATUS_W-1:0] r_status, n_status;
    logic [csa_pkg::HANDLE_W-1:0] r_res_handle, n_res_handle;
    logic [csa_pkg::OFFSET_W-1:0] r_res_offset, n_res_offset;
    logic                         r_last, n_last;

    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    csa_pkg::t_entry wr_data;
    csa_pkg::t_entry rd_data;

    logic            out_free;
    logic            in_fire;
    logic [CNTW-1:0] idx_inc;
    logic [CNTW-1:0] idx_dec;
    logic            fits;
    logic [CW-1:0]   total_ext;
    logic [CW-1:0]   vol_ext;

    csa_table #(
        .SLOTS(SLOTS)
    ) u_table (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_addr(r_idx[IW-1:0]),
        .o_rd_data(rd_data)
    );

    // The output register may be reloaded when empty or being drained this cycle.
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == csa_pkg::S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;

    assign idx_inc   = r_idx + CNTW'(1);
    assign idx_dec   = r_idx - CNTW'(1);
    assign total_ext = CW'(r_total);
    assign vol_ext   = CW'(r_vol);
    assign fits      = (r_count != CNTW'(SLOTS))
                    && ((total_ext + CW'(r_size)) <= CW'(CAPACITY));

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_handle     = r_handle;
        n_size       = r_size;
        n_count      = r_count;
        n_total      = r_total;
        n_idx        = r_idx;
        n_vol        = r_vol;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_status     = r_status;
        n_res_handle = r_res_handle;
        n_res_offset = r_res_offset;
        n_last       = r_last;
        wr_en        = 1'b0;
        wr_addr      = r_count[IW-1:0];
        wr_data      = '{owner: r_handle, size: r_size};

        case (r_state)
            csa_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_op     = i_opcode;
                    n_handle = i_owner_handle;
                    n_size   = i_request_size;
                    n_idx    = '0;
                    n_vol    = '0;
                    n_state  = (i_opcode == csa_pkg::OP_ALLOC) ? csa_pkg::S_ALLOC
                                                              : csa_pkg::S_RD;
                end
            end

            // Grant at the running total or refuse; one result either way.
            csa_pkg::S_ALLOC: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_res_handle = r_handle;
                    n_last       = 1'b1;
                    if (fits) begin
                        wr_en        = 1'b1;
                        n_count      = r_count + CNTW'(1);
                        n_total      = r_total + TW'(r_size);
                        n_status     = csa_pkg::ST_GRANTED;
                        n_res_offset = total_ext[csa_pkg::OFFSET_W-1:0];
                    end else begin
                        n_status     = csa_pkg::ST_REFUSED;
                        n_res_offset = '0;
                    end
                    n_state = csa_pkg::S_IDLE;
                end
            end

            // Table read of r_idx is in flight; end of used prefix means no match.
            csa_pkg::S_RD: begin
                if (r_idx == r_count) begin
                    if (out_free) begin
                        n_out_valid  = 1'b1;
                        n_status     = csa_pkg::ST_NOTFOUND;
                        n_res_handle = r_handle;
                        n_res_offset = '0;
                        n_last       = 1'b1;
                        n_state      = csa_pkg::S_IDLE;
                    end
                end else begin
                    n_state = csa_pkg::S_CMP;
                end
            end

            csa_pkg::S_CMP: begin
                if (rd_data.owner == r_handle) begin
                    if (out_free) begin
                        n_out_valid  = 1'b1;
                        n_status     = csa_pkg::ST_RELEASED;
                        n_res_handle = r_handle;
                        n_res_offset = vol_ext[csa_pkg::OFFSET_W-1:0];
                        n_total      = r_total - TW'(rd_data.size);
                        n_idx        = idx_inc;
                        if (idx_inc == r_count) begin
                            n_last  = 1'b1;
                            n_count = r_count - CNTW'(1);
                            n_state = csa_pkg::S_IDLE;
                        end else begin
                            n_last  = 1'b0;
                            n_state = csa_pkg::S_MRD;
                        end
                    end
                end else begin
                    n_vol   = r_vol + TW'(rd_data.size);
                    n_idx   = idx_inc;
                    n_state = csa_pkg::S_RD;
                end
            end

            csa_pkg::S_MRD: begin
                n_state = csa_pkg::S_MOVE;
            end

            // Pull entry r_idx down one place at the packed offset.
            csa_pkg::S_MOVE: begin
                if (out_free) begin
                    wr_en        = 1'b1;
                    wr_addr      = idx_dec[IW-1:0];
                    wr_data      = rd_data;
                    n_out_valid  = 1'b1;
                    n_status     = csa_pkg::ST_MOVED;
                    n_res_handle = rd_data.owner;
                    n_res_offset = vol_ext[csa_pkg::OFFSET_W-1:0];
                    n_vol        = r_vol + TW'(rd_data.size);
                    n_idx        = idx_inc;
                    if (idx_inc == r_count) begin
                        n_last  = 1'b1;
                        n_count = r_count - CNTW'(1);
                        n_state = csa_pkg::S_IDLE;
                    end else begin
                        n_last  = 1'b0;
                        n_state = csa_pkg::S_MRD;
                    end
                end
            end

            default: begin
                n_state = csa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= csa_pkg::S_IDLE;
            r_count     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and scan registers need no reset.
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_handle     <= n_handle;
        r_size       <= n_size;
        r_idx        <= n_idx;
        r_vol        <= n_vol;
        r_status     <= n_status;
        r_res_handle <= n_res_handle;
        r_res_offset <= n_res_offset;
        r_last       <= n_last;
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_result_handle = r_res_handle;
    assign o_result_offset = r_res_offset;
    assign o_last          = r_last;

endmodule

@@ sv/csa_table.sv @@
// Slot table store: owner and size per slot, one write and one registered read port.
module csa_table #(
    parameter int SLOTS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_wr_en,
    input  logic [$clog2(SLOTS)-1:0] i_wr_addr,
    input  csa_pkg::t_entry         i_wr_data,
    input  logic [$clog2(SLOTS)-1:0] i_rd_addr,
    output csa_pkg::t_entry         o_rd_data
);

    localparam int IW = $clog2(SLOTS);

    csa_pkg::t_entry r_mem [SLOTS];
    csa_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr[IW-1:0]];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/csa_checker.sv @@
// Port-level checker for the compacting slot allocator, bound to the top level.
module csa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_status,
    input logic [12:0] o_result_offset,
    input logic        o_last
);

    // Hold a pending result until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // Drop ready for the cycle after a transaction is taken.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready held high right after an accepted transaction");

    // Single-result outcomes always close their transaction.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == csa_pkg::ST_GRANTED
                     || o_status == csa_pkg::ST_REFUSED
                     || o_status == csa_pkg::ST_NOTFOUND) |-> o_last)
        else $error("single-result status without last");

    // Refusals and misses carry a zero offset.
    a_zero_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == csa_pkg::ST_REFUSED
                     || o_status == csa_pkg::ST_NOTFOUND) |-> o_result_offset == 13'd0)
        else $error("nonzero offset on refused or not found");

endmodule

bind compacting_slot_allocator csa_checker u_csa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_status       (o_status),
    .o_result_offset(o_result_offset),
    .o_last         (o_last)
);
